>>> src/slegu_pkg.sv
// Types and constants shared by the stop line endpoint geometry unit.
`timescale 1ns / 1ps

package slegu_pkg;

	typedef enum logic [0:0] {
		CFG_LINE_WIDTH   = 1'b0,
		CFG_ALONG_OFFSET = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p1_z;
		logic signed [31:0] p2_x;
		logic signed [31:0] p2_y;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] line_z;
		logic signed [31:0] sign_near_x;
		logic signed [31:0] sign_near_y;
		logic signed [31:0] sign_far_x;
		logic signed [31:0] sign_far_y;
		logic signed [31:0] sign_z;
	} geom_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pos_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic zero;
	} dir_flags_t;

	localparam logic [15:0] LINE_WIDTH_RST   = 16'd2000;
	localparam logic [15:0] ALONG_OFFSET_RST = 16'd200;

	localparam int ROOT_STEPS = 32;
	localparam int QUO_STEPS  = 31;

	localparam logic [30:0] Q_ONE = 31'h4000_0000;
	localparam logic signed [31:0] SIGN_RISE = 32'sd2000;

	// Half of 15 * 2^31 for rounding, plus a multiple of 15 * 2^31 that keeps the sum positive.
	localparam logic signed [54:0] NUM_BIAS =
		55'sd15 * ((55'sd1 <<< 30) + (55'sd1 <<< 49));
	localparam logic signed [50:0] RND_HALF = 51'sd1073741824;

	localparam logic [23:0] DIV15_RECIP  = 24'd8947849;
	localparam logic signed [33:0] DIV15_OFFSET = 34'sd262144;

endpackage

>>> src/stop_line_endpoint_geometry_unit.sv
// Stop line endpoint geometry: pipelined unit direction, line endpoints and sign points.
`timescale 1ns / 1ps

// The block takes a pair of waypoints on the pair channel and returns the stop line
// endpoints and the two sign points on the geom channel; both channels use valid and
// ready. The line width and the along-track offset are written through the cfg port
// while no transfer is in flight, a rule for the user that the block does not enforce.
// The datapath is a 77-stage pipeline: normalisation, squaring, a 32-stage square root,
// two 31-stage long dividers that share their stages, then the offset products, the
// rounding and the division by fifteen. One pair is accepted in every cycle while the
// skid register is empty; when it is full, pair_ready is low and the pipeline holds.
// Reset clears every valid bit and loads the registers with a width of 2000 mm and an
// offset of 200 mm. When the receiver stalls, the last result moves into a one-entry
// skid register and the pipeline keeps running; only once that register is full does
// the whole pipeline hold and pair_ready fall.
module stop_line_endpoint_geometry_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  slegu_pkg::cfg_reg_t  cfg_index,
	input  logic [15:0]          cfg_wdata,
	input  logic                 pair_valid,
	output logic                 pair_ready,
	input  slegu_pkg::pair_t     pair,
	output logic                 geom_valid,
	input  logic                 geom_ready,
	output slegu_pkg::geom_t     geom
);

	localparam int RS = slegu_pkg::ROOT_STEPS;
	localparam int QS = slegu_pkg::QUO_STEPS;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -34'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// One long division step: returns the quotient bit and the new remainder.
	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
		input logic [31:0] len);
		logic [32:0] r2;
		r2 = {rem, nbit};
		if (r2 >= {1'b0, len}) begin
			return {1'b1, 32'(r2 - {1'b0, len})};
		end
		return {1'b0, r2[31:0]};
	endfunction

	logic [15:0] line_width_q;
	logic [15:0] along_offset_q;
	logic        skid_q;
	slegu_pkg::geom_t skid_data_q;
	logic        adv;

	assign adv        = !skid_q;
	assign pair_ready = !skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= slegu_pkg::LINE_WIDTH_RST;
			along_offset_q <= slegu_pkg::ALONG_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slegu_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_wdata;
				slegu_pkg::CFG_ALONG_OFFSET: along_offset_q <= cfg_wdata;
			endcase
		end
	end

	// Stage 1: differences.
	logic v_s1;
	logic signed [32:0] dx_s1, dy_s1;
	slegu_pkg::pos_t pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= 33'(pair.p2_x) - 33'(pair.p1_x);
			dy_s1  <= 33'(pair.p2_y) - 33'(pair.p1_y);
			pos_s1 <= '{x: pair.p1_x, y: pair.p1_y, z: pair.p1_z};
		end
	end

	// Stage 2: magnitudes and signs.
	logic v_s2;
	logic [32:0] a_s2, b_s2;
	slegu_pkg::dir_flags_t flg_s2;
	slegu_pkg::pos_t pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2   <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			b_s2   <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
			flg_s2 <= '{neg_x: dx_s1[32], neg_y: dy_s1[32],
				zero: (dx_s1 == 33'sd0) && (dy_s1 == 33'sd0)};
			pos_s2 <= pos_s1;
		end
	end

	// Stages 3 and 4: shift the larger magnitude up to bit 32, coarse then fine.
	logic v_s3;
	logic [32:0] o_s3, a_s3, b_s3;
	slegu_pkg::dir_flags_t flg_s3;
	slegu_pkg::pos_t pos_s3;
	logic [32:0] o3, a3, b3;

	always_comb begin
		o3 = a_s2 | b_s2;
		a3 = a_s2;
		b3 = b_s2;
		if (o3[32:17] == 16'd0) begin
			o3 = o3 << 16;
			a3 = a3 << 16;
			b3 = b3 << 16;
		end
		if (o3[32:25] == 8'd0) begin
			o3 = o3 << 8;
			a3 = a3 << 8;
			b3 = b3 << 8;
		end
		if (o3[32:29] == 4'd0) begin
			o3 = o3 << 4;
			a3 = a3 << 4;
			b3 = b3 << 4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s3   <= o3;
			a_s3   <= a3;
			b_s3   <= b3;
			flg_s3 <= flg_s2;
			pos_s3 <= pos_s2;
		end
	end

	logic v_s4;
	logic [30:0] na_s4, nb_s4;
	slegu_pkg::dir_flags_t flg_s4;
	slegu_pkg::pos_t pos_s4;
	logic [32:0] o4, a4, b4;

	always_comb begin
		o4 = o_s3;
		a4 = a_s3;
		b4 = b_s3;
		if (o4[32:31] == 2'd0) begin
			o4 = o4 << 2;
			a4 = a4 << 2;
			b4 = b4 << 2;
		end
		if (!o4[32]) begin
			o4 = o4 << 1;
			a4 = a4 << 1;
			b4 = b4 << 1;
		end
		if (!o4[32]) begin
			a4 = a4 << 1;
			b4 = b4 << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s4  <= a4[32:2];
			nb_s4  <= b4[32:2];
			flg_s4 <= flg_s3;
			pos_s4 <= pos_s3;
		end
	end

	// Stage 5: squares. Stage 6: their sum.
	logic v_s5, v_s6;
	logic [61:0] asq_s5, bsq_s5;
	logic [62:0] sum_s6;
	logic [30:0] na_s5, nb_s5, na_s6, nb_s6;
	slegu_pkg::dir_flags_t flg_s5, flg_s6;
	slegu_pkg::pos_t pos_s5, pos_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			asq_s5 <= 62'(na_s4) * 62'(na_s4);
			bsq_s5 <= 62'(nb_s4) * 62'(nb_s4);
			na_s5  <= na_s4;
			nb_s5  <= nb_s4;
			flg_s5 <= flg_s4;
			pos_s5 <= pos_s4;
			sum_s6 <= 63'(asq_s5) + 63'(bsq_s5);
			na_s6  <= na_s5;
			nb_s6  <= nb_s5;
			flg_s6 <= flg_s5;
			pos_s6 <= pos_s5;
		end
	end

	// Stage block 7: square root, one result bit per stage.
	logic        sq_v_s7    [RS];
	logic [63:0] sq_rad_s7  [RS];
	logic [32:0] sq_rem_s7  [RS];
	logic [31:0] sq_root_s7 [RS];
	logic [30:0] sq_na_s7   [RS];
	logic [30:0] sq_nb_s7   [RS];
	slegu_pkg::dir_flags_t sq_flg_s7 [RS];
	slegu_pkg::pos_t       sq_pos_s7 [RS];

	for (genvar k = 0; k < RS; k++) begin : g_root
		logic        v_in;
		logic [63:0] rad_in;
		logic [32:0] rem_in;
		logic [31:0] root_in;
		logic [30:0] na_in, nb_in;
		slegu_pkg::dir_flags_t flg_in;
		slegu_pkg::pos_t       pos_in;
		logic [34:0] acc, trial;

		if (k == 0) begin : g_first
			assign v_in    = v_s6;
			assign rad_in  = {1'b0, sum_s6};
			assign rem_in  = '0;
			assign root_in = '0;
			assign na_in   = na_s6;
			assign nb_in   = nb_s6;
			assign flg_in  = flg_s6;
			assign pos_in  = pos_s6;
		end else begin : g_next
			assign v_in    = sq_v_s7[k-1];
			assign rad_in  = sq_rad_s7[k-1];
			assign rem_in  = sq_rem_s7[k-1];
			assign root_in = sq_root_s7[k-1];
			assign na_in   = sq_na_s7[k-1];
			assign nb_in   = sq_nb_s7[k-1];
			assign flg_in  = sq_flg_s7[k-1];
			assign pos_in  = sq_pos_s7[k-1];
		end

		assign acc   = {rem_in, rad_in[63:62]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s7[k] <= 1'b0;
			end else if (adv) begin
				sq_v_s7[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad_s7[k] <= rad_in << 2;
				if (acc >= trial) begin
					sq_rem_s7[k]  <= 33'(acc - trial);
					sq_root_s7[k] <= {root_in[30:0], 1'b1};
				end else begin
					sq_rem_s7[k]  <= acc[32:0];
					sq_root_s7[k] <= {root_in[30:0], 1'b0};
				end
				sq_na_s7[k]  <= na_in;
				sq_nb_s7[k]  <= nb_in;
				sq_flg_s7[k] <= flg_in;
				sq_pos_s7[k] <= pos_in;
			end
		end
	end

	// Stage 8: rounded numerators.
	logic v_s8;
	logic [31:0] len_s8;
	logic [61:0] num_a_s8, num_b_s8;
	slegu_pkg::dir_flags_t flg_s8;
	slegu_pkg::pos_t pos_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= sq_v_s7[RS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s8   <= sq_root_s7[RS-1];
			num_a_s8 <= 62'({sq_na_s7[RS-1], 30'd0}) + 62'(sq_root_s7[RS-1][31:1]);
			num_b_s8 <= 62'({sq_nb_s7[RS-1], 30'd0}) + 62'(sq_root_s7[RS-1][31:1]);
			flg_s8   <= sq_flg_s7[RS-1];
			pos_s8   <= sq_pos_s7[RS-1];
		end
	end

	// Stage block 9: two long dividers by the length, one quotient bit per stage.
	logic        dv_v_s9     [QS];
	logic [31:0] dv_len_s9   [QS];
	logic [31:0] dv_rem_a_s9 [QS];
	logic [31:0] dv_rem_b_s9 [QS];
	logic [30:0] dv_low_a_s9 [QS];
	logic [30:0] dv_low_b_s9 [QS];
	logic [30:0] dv_quo_a_s9 [QS];
	logic [30:0] dv_quo_b_s9 [QS];
	slegu_pkg::dir_flags_t dv_flg_s9 [QS];
	slegu_pkg::pos_t       dv_pos_s9 [QS];

	for (genvar k = 0; k < QS; k++) begin : g_div
		logic        v_in;
		logic [31:0] len_in, rem_a_in, rem_b_in;
		logic [30:0] low_a_in, low_b_in, quo_a_in, quo_b_in;
		slegu_pkg::dir_flags_t flg_in;
		slegu_pkg::pos_t       pos_in;
		logic [32:0] step_a, step_b;

		if (k == 0) begin : g_first
			assign v_in     = v_s8;
			assign len_in   = len_s8;
			assign rem_a_in = {1'b0, num_a_s8[61:31]};
			assign rem_b_in = {1'b0, num_b_s8[61:31]};
			assign low_a_in = num_a_s8[30:0];
			assign low_b_in = num_b_s8[30:0];
			assign quo_a_in = '0;
			assign quo_b_in = '0;
			assign flg_in   = flg_s8;
			assign pos_in   = pos_s8;
		end else begin : g_next
			assign v_in     = dv_v_s9[k-1];
			assign len_in   = dv_len_s9[k-1];
			assign rem_a_in = dv_rem_a_s9[k-1];
			assign rem_b_in = dv_rem_b_s9[k-1];
			assign low_a_in = dv_low_a_s9[k-1];
			assign low_b_in = dv_low_b_s9[k-1];
			assign quo_a_in = dv_quo_a_s9[k-1];
			assign quo_b_in = dv_quo_b_s9[k-1];
			assign flg_in   = dv_flg_s9[k-1];
			assign pos_in   = dv_pos_s9[k-1];
		end

		assign step_a = div_step(rem_a_in, low_a_in[30], len_in);
		assign step_b = div_step(rem_b_in, low_b_in[30], len_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s9[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s9[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_len_s9[k]   <= len_in;
				dv_rem_a_s9[k] <= step_a[31:0];
				dv_rem_b_s9[k] <= step_b[31:0];
				dv_low_a_s9[k] <= low_a_in << 1;
				dv_low_b_s9[k] <= low_b_in << 1;
				dv_quo_a_s9[k] <= {quo_a_in[29:0], step_a[32]};
				dv_quo_b_s9[k] <= {quo_b_in[29:0], step_b[32]};
				dv_flg_s9[k]   <= flg_in;
				dv_pos_s9[k]   <= pos_in;
			end
		end
	end

	// Stage 10: signed unit vector in Q2.30.
	logic v_s10;
	logic signed [31:0] ux_s10, uy_s10;
	slegu_pkg::pos_t pos_s10;
	logic [30:0] qa_cap, qb_cap;
	slegu_pkg::dir_flags_t flg_d;

	assign flg_d  = dv_flg_s9[QS-1];
	assign qa_cap = (dv_quo_a_s9[QS-1] > slegu_pkg::Q_ONE) ? slegu_pkg::Q_ONE
		: dv_quo_a_s9[QS-1];
	assign qb_cap = (dv_quo_b_s9[QS-1] > slegu_pkg::Q_ONE) ? slegu_pkg::Q_ONE
		: dv_quo_b_s9[QS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= dv_v_s9[QS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flg_d.zero) begin
				ux_s10 <= 32'(slegu_pkg::Q_ONE);
				uy_s10 <= 32'sd0;
			end else begin
				ux_s10 <= flg_d.neg_x ? -32'(qa_cap) : 32'(qa_cap);
				uy_s10 <= flg_d.neg_y ? -32'(qb_cap) : 32'(qb_cap);
			end
			pos_s10 <= dv_pos_s9[QS-1];
		end
	end

	// Stage 11: products with the width and twice the offset, in units of 2^-31 mm.
	logic v_s11;
	logic signed [48:0] wux_s11, wuy_s11;
	logic signed [49:0] ofx_s11, ofy_s11;
	slegu_pkg::pos_t pos_s11;
	logic signed [16:0] w_sg;
	logic signed [17:0] off2_sg;

	assign w_sg    = signed'({1'b0, line_width_q});
	assign off2_sg = signed'({1'b0, along_offset_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wux_s11 <= 49'(w_sg) * 49'(ux_s10);
			wuy_s11 <= 49'(w_sg) * 49'(uy_s10);
			ofx_s11 <= 50'(off2_sg) * 50'(ux_s10);
			ofy_s11 <= 50'(off2_sg) * 50'(uy_s10);
			pos_s11 <= pos_s10;
		end
	end

	// Stage 12: endpoint offsets from the first point.
	logic v_s12;
	logic signed [50:0] sx_s12, sy_s12, ex_s12, ey_s12;
	logic signed [48:0] wux_s12, wuy_s12;
	slegu_pkg::pos_t pos_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s12  <= 51'(ofx_s11) - 51'(wuy_s11);
			sy_s12  <= 51'(ofy_s11) + 51'(wux_s11);
			ex_s12  <= 51'(ofx_s11) + 51'(wuy_s11);
			ey_s12  <= 51'(ofy_s11) - 51'(wux_s11);
			wux_s12 <= wux_s11;
			wuy_s12 <= wuy_s11;
			pos_s12 <= pos_s11;
		end
	end

	// Stage 13: sign point numerators over 15 * 2^31.
	logic v_s13;
	logic signed [54:0] nx_s13, ny_s13, fx_s13, fy_s13;
	logic signed [50:0] sx_s13, sy_s13, ex_s13, ey_s13;
	slegu_pkg::pos_t pos_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s13  <= 55'sd15 * 55'(ex_s12) + 55'sd6 * 55'(wuy_s12);
			fx_s13  <= 55'sd15 * 55'(ex_s12) + 55'sd10 * 55'(wuy_s12);
			ny_s13  <= 55'sd15 * 55'(ey_s12) - 55'sd6 * 55'(wux_s12);
			fy_s13  <= 55'sd15 * 55'(ey_s12) - 55'sd10 * 55'(wux_s12);
			sx_s13  <= sx_s12;
			sy_s13  <= sy_s12;
			ex_s13  <= ex_s12;
			ey_s13  <= ey_s12;
			pos_s13 <= pos_s12;
		end
	end

	// Stage 14: rounding of the endpoints and biased quotients by 2^31.
	logic v_s14;
	logic [22:0] xnx_s14, xny_s14, xfx_s14, xfy_s14;
	logic signed [19:0] rsx_s14, rsy_s14, rex_s14, rey_s14;
	slegu_pkg::pos_t pos_s14;
	logic signed [54:0] bnx, bny, bfx, bfy;
	logic signed [50:0] hsx, hsy, hex, hey;

	assign bnx = nx_s13 + slegu_pkg::NUM_BIAS;
	assign bny = ny_s13 + slegu_pkg::NUM_BIAS;
	assign bfx = fx_s13 + slegu_pkg::NUM_BIAS;
	assign bfy = fy_s13 + slegu_pkg::NUM_BIAS;
	assign hsx = sx_s13 + slegu_pkg::RND_HALF;
	assign hsy = sy_s13 + slegu_pkg::RND_HALF;
	assign hex = ex_s13 + slegu_pkg::RND_HALF;
	assign hey = ey_s13 + slegu_pkg::RND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
		end else if (adv) begin
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xnx_s14 <= bnx[53:31];
			xny_s14 <= bny[53:31];
			xfx_s14 <= bfx[53:31];
			xfy_s14 <= bfy[53:31];
			rsx_s14 <= hsx[50:31];
			rsy_s14 <= hsy[50:31];
			rex_s14 <= hex[50:31];
			rey_s14 <= hey[50:31];
			pos_s14 <= pos_s13;
		end
	end

	// Stage 15: division by fifteen through the reciprocal.
	logic v_s15;
	logic [18:0] qnx_s15, qny_s15, qfx_s15, qfy_s15;
	logic signed [19:0] rsx_s15, rsy_s15, rex_s15, rey_s15;
	slegu_pkg::pos_t pos_s15;
	logic [46:0] pnx, pny, pfx, pfy;

	assign pnx = 47'(xnx_s14) * 47'(slegu_pkg::DIV15_RECIP);
	assign pny = 47'(xny_s14) * 47'(slegu_pkg::DIV15_RECIP);
	assign pfx = 47'(xfx_s14) * 47'(slegu_pkg::DIV15_RECIP);
	assign pfy = 47'(xfy_s14) * 47'(slegu_pkg::DIV15_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else if (adv) begin
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qnx_s15 <= pnx[45:27];
			qny_s15 <= pny[45:27];
			qfx_s15 <= pfx[45:27];
			qfy_s15 <= pfy[45:27];
			rsx_s15 <= rsx_s14;
			rsy_s15 <= rsy_s14;
			rex_s15 <= rex_s14;
			rey_s15 <= rey_s14;
			pos_s15 <= pos_s14;
		end
	end

	// Stage 16: absolute positions with saturation.
	logic v_s16;
	slegu_pkg::geom_t geom_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else if (adv) begin
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geom_s16.start_x <= sat32(34'(pos_s15.x) + 34'(rsx_s15));
			geom_s16.start_y <= sat32(34'(pos_s15.y) + 34'(rsy_s15));
			geom_s16.end_x   <= sat32(34'(pos_s15.x) + 34'(rex_s15));
			geom_s16.end_y   <= sat32(34'(pos_s15.y) + 34'(rey_s15));
			geom_s16.line_z  <= pos_s15.z;
			geom_s16.sign_near_x <= sat32(34'(pos_s15.x)
				+ 34'(signed'({1'b0, qnx_s15})) - slegu_pkg::DIV15_OFFSET);
			geom_s16.sign_near_y <= sat32(34'(pos_s15.y)
				+ 34'(signed'({1'b0, qny_s15})) - slegu_pkg::DIV15_OFFSET);
			geom_s16.sign_far_x  <= sat32(34'(pos_s15.x)
				+ 34'(signed'({1'b0, qfx_s15})) - slegu_pkg::DIV15_OFFSET);
			geom_s16.sign_far_y  <= sat32(34'(pos_s15.y)
				+ 34'(signed'({1'b0, qfy_s15})) - slegu_pkg::DIV15_OFFSET);
			geom_s16.sign_z  <= sat32(34'(pos_s15.z) + 34'(slegu_pkg::SIGN_RISE));
		end
	end

	// Skid register: catches the last result when the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (geom_ready) begin
				skid_q <= 1'b0;
			end
		end else if (v_s16 && !geom_ready) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_data_q <= geom_s16;
		end
	end

	assign geom_valid = skid_q || v_s16;
	assign geom       = skid_q ? skid_data_q : geom_s16;

	a_frozen_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |=> $stable({v_s1, v_s8, v_s16}))
		else $error("pipeline moved while the skid register was full");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		v_s16 && !skid_q && !geom_ready |=> skid_q)
		else $error("stalled result was not captured");

	a_len_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !flg_s8.zero |-> len_s8[31:30] != 2'b00)
		else $error("length below 2^30 after normalisation");

	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s9[QS-1] && !flg_d.zero |->
		dv_quo_a_s9[QS-1] <= slegu_pkg::Q_ONE && dv_quo_b_s9[QS-1] <= slegu_pkg::Q_ONE)
		else $error("unit vector component above one");

endmodule

>>> tb/sv/tb_stop_line_endpoint_geometry_unit.sv
// Self-checking testbench for the stop line endpoint geometry unit.
`timescale 1ns / 1ps

module tb_stop_line_endpoint_geometry_unit;

	class geom_scoreboard;
		logic [15:0] width_mm;
		logic [15:0] offset_mm;
		slegu_pkg::geom_t pending[$];
		int mismatches;
		int reported;

		function new();
			width_mm = slegu_pkg::LINE_WIDTH_RST;
			offset_mm = slegu_pkg::ALONG_OFFSET_RST;
			mismatches = 0;
			reported = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		// Nearest integer of t / d, ties upwards.
		function longint nearest_div(longint t, longint unsigned d);
			longint unsigned biased;
			biased = longint'(t) + longint'(d << 20);
			return longint'((biased + d / 2) / d) - (longint'(1) << 20);
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function slegu_pkg::geom_t line_geometry(slegu_pkg::pair_t p);
			longint p1x, p1y, p1z, dx, dy, ux, uy, w, off2;
			longint sx, sy, ex, ey, spx, spy;
			longint unsigned a, b, m, len, qa, qb, q31, q31x15;
			slegu_pkg::geom_t g;
			p1x = p.p1_x;
			p1y = p.p1_y;
			p1z = p.p1_z;
			dx = longint'(p.p2_x) - p1x;
			dy = longint'(p.p2_y) - p1y;
			if (dx == 0 && dy == 0) begin
				ux = 64'sd1 << 30;
				uy = 0;
			end else begin
				a = dx < 0 ? -dx : dx;
				b = dy < 0 ? -dy : dy;
				m = a > b ? a : b;
				while (m >= (64'd1 << 31)) begin
					a = a >> 1;
					b = b >> 1;
					m = m >> 1;
				end
				while (m < (64'd1 << 30)) begin
					a = a << 1;
					b = b << 1;
					m = m << 1;
				end
				len = int_sqrt(a * a + b * b);
				qa = ((a << 30) + len / 2) / len;
				qb = ((b << 30) + len / 2) / len;
				if (qa > (64'd1 << 30)) qa = 64'd1 << 30;
				if (qb > (64'd1 << 30)) qb = 64'd1 << 30;
				ux = dx < 0 ? -longint'(qa) : longint'(qa);
				uy = dy < 0 ? -longint'(qb) : longint'(qb);
			end
			w = width_mm;
			off2 = 2 * longint'(offset_mm);
			sx = -w * uy + off2 * ux;
			sy = w * ux + off2 * uy;
			ex = w * uy + off2 * ux;
			ey = -w * ux + off2 * uy;
			spx = ex - sx;
			spy = ey - sy;
			q31 = 64'd1 << 31;
			q31x15 = q31 * 15;
			g.start_x = 32'(clamp32(p1x + nearest_div(sx, q31)));
			g.start_y = 32'(clamp32(p1y + nearest_div(sy, q31)));
			g.end_x = 32'(clamp32(p1x + nearest_div(ex, q31)));
			g.end_y = 32'(clamp32(p1y + nearest_div(ey, q31)));
			g.line_z = p.p1_z;
			g.sign_near_x = 32'(clamp32(p1x + nearest_div(15 * ex + 3 * spx, q31x15)));
			g.sign_near_y = 32'(clamp32(p1y + nearest_div(15 * ey + 3 * spy, q31x15)));
			g.sign_far_x = 32'(clamp32(p1x + nearest_div(15 * ex + 5 * spx, q31x15)));
			g.sign_far_y = 32'(clamp32(p1y + nearest_div(15 * ey + 5 * spy, q31x15)));
			g.sign_z = 32'(clamp32(p1z + 2000));
			return g;
		endfunction

		function void note_pair(slegu_pkg::pair_t p);
			pending = {pending, line_geometry(p)};
		endfunction

		function void check_geom(slegu_pkg::geom_t got);
			slegu_pkg::geom_t want;
			string names[10];
			logic [31:0] w_f, g_f;
			bit bad;
			names = '{"start_x", "start_y", "end_x", "end_y", "line_z",
				"sign_near_x", "sign_near_y", "sign_far_x", "sign_far_y", "sign_z"};
			if (pending.size() == 0) begin
				mismatches++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result transfer: %h", got);
				end
				return;
			end
			want = pending.pop_front();
			bad = 0;
			for (int k = 0; k < 10; k++) begin
				w_f = want[319 - 32 * k -: 32];
				g_f = got[319 - 32 * k -: 32];
				if (w_f !== g_f) begin
					bad = 1;
					if (reported < 10) begin
						reported++;
						$display("%s: expected %0d, got %0d", names[k],
							$signed(w_f), $signed(g_f));
					end
				end
			end
			if (bad) mismatches++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	slegu_pkg::cfg_reg_t cfg_index;
	logic [15:0] cfg_wdata;
	logic pair_valid;
	logic pair_ready;
	slegu_pkg::pair_t pair;
	logic geom_valid;
	logic geom_ready;
	slegu_pkg::geom_t geom;

	geom_scoreboard sb;
	int snd_idle;
	int rcv_idle;
	int cycles = 0;

	stop_line_endpoint_geometry_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pair_valid(pair_valid),
		.pair_ready(pair_ready),
		.pair(pair),
		.geom_valid(geom_valid),
		.geom_ready(geom_ready),
		.geom(geom)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) geom_ready <= 1'b0;
		else geom_ready <= ($urandom_range(99) >= rcv_idle);
		if (arst_n && pair_valid && pair_ready) sb.note_pair(pair);
		if (arst_n && geom_valid && geom_ready) sb.check_geom(geom);
	end

	task automatic send_pair(slegu_pkg::pair_t p);
		if ($urandom_range(99) < snd_idle) begin
			pair_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < snd_idle) @(posedge clk);
		end
		pair <= p;
		pair_valid <= 1'b1;
		forever begin
			@(negedge clk);
			if (pair_ready) break;
		end
		@(posedge clk);
	endtask

	task automatic send_xy(int x1, int y1, int z1, int x2, int y2);
		slegu_pkg::pair_t p;
		p.p1_x = x1;
		p.p1_y = y1;
		p.p1_z = z1;
		p.p2_x = x2;
		p.p2_y = y2;
		send_pair(p);
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(slegu_pkg::cfg_reg_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == slegu_pkg::CFG_LINE_WIDTH) sb.width_mm = val;
		else sb.offset_mm = val;
	endtask

	function automatic int edge_coord();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff - $urandom_range(70000);
			1: return 32'h8000_0000 + $urandom_range(70000);
			2: return $urandom_range(2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_pair();
		int x1, y1, z1, x2, y2, r;
		r = $urandom_range(99);
		x1 = (r < 30) ? edge_coord() : $urandom;
		y1 = (r < 30) ? edge_coord() : $urandom;
		z1 = ($urandom_range(9) == 0) ? edge_coord() : $urandom;
		if (r < 5) begin
			x2 = x1;
			y2 = y1;
		end else if (r < 40) begin
			x2 = x1 + $signed($urandom_range(200)) - 100;
			y2 = y1 + $signed($urandom_range(200)) - 100;
		end else if (r < 70) begin
			x2 = x1 + ($signed($urandom) >>> $urandom_range(31));
			y2 = y1 + ($signed($urandom) >>> $urandom_range(31));
		end else begin
			x2 = $urandom;
			y2 = $urandom;
		end
		send_xy(x1, y1, z1, x2, y2);
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = slegu_pkg::CFG_LINE_WIDTH;
		cfg_wdata = '0;
		pair_valid = 1'b0;
		pair = '0;
		snd_idle = 16;
		rcv_idle = 65;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_xy(0, 0, 0, 0, 0);
		send_xy(1000, -500, 7, 1000, -500);
		send_xy(0, 0, 0, 1, 0);
		send_xy(0, 0, 0, -1, 0);
		send_xy(0, 0, 0, 0, 1);
		send_xy(0, 0, 0, 0, -1);
		send_xy(0, 0, 0, 5, 5);
		send_xy(0, 0, 0, -3, 4);
		send_xy(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		send_xy(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff);
		send_xy(32'h7fff_ffff, 0, 32'h7fff_f000, 32'h7fff_fff0, 100);
		send_xy(32'h8000_0000, 32'h7fff_ffff, -1, 32'h8000_0000, 0);
		send_xy(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_f830, 32'h8000_0000, 32'h8000_0000);
		send_xy(-5, 17, 3, 32'h7fff_ffff, 32'h8000_0001);
		send_xy(123456, -654321, 42, 123457, -654319);
		send_xy(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					write_reg(slegu_pkg::CFG_LINE_WIDTH, 16'hffff);
					write_reg(slegu_pkg::CFG_ALONG_OFFSET, 16'hffff);
				end
				1: begin
					write_reg(slegu_pkg::CFG_LINE_WIDTH, 16'h0000);
					write_reg(slegu_pkg::CFG_ALONG_OFFSET, 16'h0000);
					snd_idle = 65;
					rcv_idle = 16;
				end
				default: begin
					write_reg(slegu_pkg::CFG_LINE_WIDTH, 16'($urandom_range(65535)));
					write_reg(slegu_pkg::CFG_ALONG_OFFSET, 16'($urandom_range(65535)));
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			for (int n = 0; n < 545; n++) begin
				if (ph == 2 && n == 270) begin
					drain();
					write_reg(slegu_pkg::CFG_LINE_WIDTH, 16'($urandom_range(65535)));
					write_reg(slegu_pkg::CFG_ALONG_OFFSET, 16'($urandom_range(65535)));
				end
				random_pair();
			end
			drain();
		end

		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
